FILE: hdl/signed_integer_to_seven_segment_macros.svh
// assertion macros for the seven-segment decoder checks
`ifndef SIGNED_INTEGER_TO_SEVEN_SEGMENT_MACROS_SVH
`define SIGNED_INTEGER_TO_SEVEN_SEGMENT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define SITS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sits check failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock edge
`define SITS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sits check failed: next-cycle implication");

`endif

FILE: hdl/sits_pkg.sv
package sits_pkg;

   // display and conversion sizes
   localparam int NUM_POS             = 8;
   localparam int SEG_W               = 8;
   localparam int BIN_WIDTH           = 32;
   localparam int BCD_DIGITS          = 10;
   localparam int DIGIT_W             = 4;
   localparam int DIGIT_COUNT_DEFAULT = 8;

   // active-low segment codes, bit7 always one
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
   localparam logic [SEG_W-1:0] SEG_DASH  = 8'hBF;
   localparam logic [SEG_W-1:0] SEG_NINE  = 8'h90;

   typedef logic [BCD_DIGITS*DIGIT_W-1:0] bcd_type;
   typedef logic [BIN_WIDTH-1:0]          bin_type;

   // decimal digit to active-low segment code
   function automatic logic [SEG_W-1:0] seg_digit(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] code;
      case (d)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/sits_dabble.sv
module sits_dabble (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sits_pkg::bin_type mag,
   output logic              done,
   output sits_pkg::bcd_type bcd
);
   import sits_pkg::*;

   localparam int CNT_W = $clog2(BIN_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_WIDTH - 1);

   bin_type          bin_ff, bin_in;
   bcd_type          bcd_ff, bcd_in, adj;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // add three to every digit of five or more
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // one shift step per cycle while busy
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = mag;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bin_in   = {bin_ff[BIN_WIDTH-2:0], 1'b0};
         bcd_in   = {adj[BCD_DIGITS*DIGIT_W-2:0], bin_ff[BIN_WIDTH-1]};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

FILE: hdl/signed_integer_to_seven_segment.sv
// channel   dir   beat contents
// req_      in    tdata[31:0] value (signed)
// rsp_      out   tdata[63:0] symbol_0 .. symbol_7, 8 bits each
//
// a value goes from accept to result through 32 shift-add-3 steps in
// the dabble unit, a registered done flag and the formatting of the codes
// req_tready is low from accept until the result is loaded into the
// output register; a stalled result holds and a new value may be taken
// meanwhile. synchronous reset clears the sequencer and output valid.
module signed_integer_to_seven_segment #(
   parameter int DIGIT_COUNT = sits_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // tdata fields: value[31:0]
   input  logic [sits_pkg::BIN_WIDTH-1:0]           req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // tdata fields: symbol_0[7:0], symbol_1[15:8], ... symbol_7[63:56]
   output logic [sits_pkg::NUM_POS*sits_pkg::SEG_W-1:0] rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready
);
   import sits_pkg::*;

   localparam logic [DIGIT_W-1:0] WINDOW    = DIGIT_W'(DIGIT_COUNT);
   localparam logic [DIGIT_W-1:0] WINDOW_M1 = DIGIT_W'(DIGIT_COUNT - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_DONE} state_type;

   state_type                   state_ff;
   logic                        neg_ff;
   logic                        rsp_tvalid_ff;
   logic [NUM_POS*SEG_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic                        req_take, load;
   bin_type                     mag;
   bcd_type                     bcd;
   logic                        conv_done;
   logic [DIGIT_W-1:0]          n_digits;
   logic                        pos_over, neg_over;
   logic [SEG_W-1:0]            sym;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign load       = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // magnitude of the two's complement input
   assign mag = req_tdata[BIN_WIDTH-1] ? (BIN_WIDTH'(0) - req_tdata) : req_tdata;

   sits_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .mag   (mag),
      .done  (conv_done),
      .bcd   (bcd)
   );

   // digit count, at least one for zero
   always_comb begin
      n_digits = DIGIT_W'(1);
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
            n_digits = DIGIT_W'(i + 1);
         end
      end
   end

   assign pos_over = !neg_ff && (n_digits > WINDOW);
   assign neg_over = neg_ff && (n_digits > WINDOW_M1);

   // per-position segment codes, k counts from the right
   always_comb begin
      rsp_tdata_in = '0;
      sym          = SEG_BLANK;
      for (int k = 0; k < NUM_POS; k++) begin
         if (k >= DIGIT_COUNT) begin
            sym = SEG_BLANK;
         end else if (pos_over) begin
            sym = SEG_NINE;
         end else if (neg_over) begin
            sym = SEG_DASH;
         end else if (DIGIT_W'(k) < n_digits) begin
            sym = seg_digit(bcd[k*DIGIT_W +: DIGIT_W]);
         end else if (neg_ff && (DIGIT_W'(k) == n_digits)) begin
            sym = SEG_DASH;
         end else begin
            sym = SEG_BLANK;
         end
         rsp_tdata_in[(NUM_POS-1-k)*SEG_W +: SEG_W] = sym;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (req_take) begin
         neg_ff <= req_tdata[BIN_WIDTH-1];
      end
      if (load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               if (conv_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

FILE: hdl/sits_checker.sv
`include "signed_integer_to_seven_segment_macros.svh"

module sits_checker (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         req_tvalid,
   input logic                                         req_tready,
   input logic [sits_pkg::NUM_POS*sits_pkg::SEG_W-1:0] rsp_tdata,
   input logic                                         rsp_tvalid,
   input logic                                         rsp_tready
);
   import sits_pkg::*;

   logic req_beat;
   logic marks_set;

   assign req_beat  = req_tvalid && req_tready;
   assign marks_set = rsp_tdata[7] && rsp_tdata[15] && rsp_tdata[23] && rsp_tdata[31]
                      && rsp_tdata[39] && rsp_tdata[47] && rsp_tdata[55] && rsp_tdata[63];

   // stalled result beat holds
   `SITS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // busy right after a value is taken
   `SITS_ASSERT_NEXT(a_busy_after_take, req_beat, !req_tready)

   // still busy well into the conversion
   `SITS_ASSERT_IMPLY(a_busy_long, req_beat, ##16 !req_tready)

   // no result appears the cycle after a value is taken
   `SITS_ASSERT_NEXT(a_no_early_rsp, req_beat, !rsp_tvalid || $past(rsp_tvalid))

   // every shown code keeps its top bit high
   `SITS_ASSERT_IMPLY(a_top_bits, rsp_tvalid, marks_set)

endmodule

bind signed_integer_to_seven_segment sits_checker u_checker (.*);
